[src/pcdp_pkg.sv]
// Shared constants, types and reset values for the PWM capture duty/period block.
package pcdp_pkg;

  localparam int CHANNELS      = 4;
  localparam int NREGS         = 4;
  localparam int TIME_W        = 16;
  localparam int CHAN_W        = 2;
  localparam int DUTY_W        = 14;
  localparam int CFG_INDEX_W   = 8;
  localparam int CFG_DATA_W    = 16;
  localparam int PROD_W        = TIME_W + DUTY_W;
  localparam int DIV_CNT_W     = $clog2(DUTY_W);

  localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(10000);

  localparam logic [TIME_W-1:0] NOMINAL_RESET [NREGS] = '{
    TIME_W'(20000), TIME_W'(20000), TIME_W'(40000), TIME_W'(25000)
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

[src/pcdp_intf.sv]
// Handshake interfaces for edge requests, results and register writes.
interface pcdp_edge_if;
  logic                        valid;
  logic                        ready;
  logic [pcdp_pkg::TIME_W-1:0] edge_time;
  logic [pcdp_pkg::CHAN_W-1:0] channel;
  logic                        level;
  modport source (output valid, edge_time, channel, level, input ready);
  modport sink (input valid, edge_time, channel, level, output ready);
endinterface

interface pcdp_result_if;
  logic                        valid;
  logic                        ready;
  logic [pcdp_pkg::DUTY_W-1:0] duty;
  logic [pcdp_pkg::TIME_W-1:0] period;
  logic                        duty_updated;
  logic                        period_accepted;
  modport source (output valid, duty, period, duty_updated, period_accepted, input ready);
  modport sink (input valid, duty, period, duty_updated, period_accepted, output ready);
endinterface

interface pcdp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pcdp_pkg::CFG_INDEX_W-1:0] index;
  logic [pcdp_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/pwm_capture_duty_period_core.sv]
// PWM input capture: per-channel period acceptance and serial duty computation.
//
// Usage:
//   edges   - one request per captured edge: edge_time, channel, level.
//   results - one result per edge: duty, period and the two update flags.
//   cfg     - register writes, index 0..3 selects nominal_period_N; other
//             indexes are dropped. Always ready; write only while idle.
// Processing:
//   A rising edge or a falling edge that does not update duty is evaluated,
//   then the result register is loaded. A falling edge that updates duty
//   runs one 16x14 multiply and then a shared restoring divide-step unit
//   that yields one quotient bit per cycle, 14 bits in all. The next request
//   is taken only in idle, after the result is loaded; one item is in flight
//   at a time.
// Reset (rst, synchronous): nominal periods and measured periods return to
//   their default values, edge times and duty clear, no result is pending.
// Stall: a finished result waits in the output register; the core holds in
//   its final state until the receiver takes the pending result, so no
//   result is ever overwritten or dropped.
module pwm_capture_duty_period_core #(
  parameter int CHANNELS = pcdp_pkg::CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst,
  pcdp_edge_if.sink             edges,
  pcdp_result_if.source         results,
  pcdp_cfg_if.sink              cfg
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW   = pcdp_pkg::TIME_W;
  localparam int DW   = pcdp_pkg::DUTY_W;
  localparam int PW   = pcdp_pkg::PROD_W;
  localparam int CW   = pcdp_pkg::DIV_CNT_W;

  // Configuration registers.
  logic [TW-1:0] nominal_period [pcdp_pkg::NREGS];

  // Per-channel measurement state.
  logic [TW-1:0] last_edge_time  [CHANNELS];
  logic [TW-1:0] last_rise_time  [CHANNELS];
  logic [TW-1:0] measured_period [CHANNELS];
  logic [DW-1:0] duty_value      [CHANNELS];

  pcdp_pkg::state_t state, state_next;

  // Latched request.
  logic [TW-1:0]                 t_r;
  logic [pcdp_pkg::CHAN_W-1:0]   ch_r;
  logic                          lvl_r;

  // Divide datapath.
  logic [TW-1:0] high_r;
  logic [TW-1:0] per_r;
  logic [TW-1:0] rem;
  logic [DW-1:0] low_bits;
  logic [DW-2:0] quot;
  logic [CW-1:0] cnt;

  logic dupd, pacc;

  // Output register.
  logic          out_valid;
  logic [DW-1:0] out_duty;
  logic [TW-1:0] out_period;
  logic          out_dupd;
  logic          out_pacc;

  logic          in_fire;
  logic          ch_ok;
  logic [CH_W-1:0] chi;
  logic [TW-1:0] ival, high;
  logic [TW:0]   nom_ext, win_hi, win_lo;
  logic          in_window;
  logic          div_needed;
  logic [PW-1:0] prod;
  logic [TW:0]   trial;
  logic [TW+1:0] diff;
  logic          ge;
  logic          out_free;

  assign edges.ready = (state == pcdp_pkg::ST_IDLE);
  assign in_fire     = edges.valid && edges.ready;
  assign cfg.ready   = 1'b1;

  assign ch_ok = (int'(ch_r) < CHANNELS);
  assign chi   = ch_r[CH_W-1:0];

  // Rising edge: acceptance window formed in 17 bits.
  assign ival      = t_r - last_rise_time[chi];
  assign nom_ext   = {1'b0, nominal_period[ch_r]};
  assign win_hi    = nom_ext + (nom_ext >> 2);
  assign win_lo    = nom_ext - (nom_ext >> 2);
  assign in_window = ({1'b0, ival} < win_hi) && ({1'b0, ival} > win_lo);

  // Falling edge: high time must lie below a nonzero period.
  assign high       = t_r - last_edge_time[chi];
  assign div_needed = (high < measured_period[chi]) && (measured_period[chi] != '0);

  assign prod = {{DW{1'b0}}, high_r} * {{TW{1'b0}}, pcdp_pkg::DUTY_FULL};

  // One restoring divide step: shift in the next dividend bit, try subtract.
  assign trial = {rem, low_bits[DW-1]};
  assign diff  = {1'b0, trial} - {2'b00, per_r};
  assign ge    = ~diff[TW+1];

  assign out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcdp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pcdp_pkg::ST_IDLE: begin
        if (in_fire) state_next = pcdp_pkg::ST_EVAL;
      end
      pcdp_pkg::ST_EVAL: begin
        if (ch_ok && !lvl_r && div_needed) state_next = pcdp_pkg::ST_MUL;
        else state_next = pcdp_pkg::ST_DONE;
      end
      pcdp_pkg::ST_MUL: begin
        state_next = pcdp_pkg::ST_DIV;
      end
      pcdp_pkg::ST_DIV: begin
        if (cnt == '0) state_next = pcdp_pkg::ST_DONE;
      end
      pcdp_pkg::ST_DONE: begin
        if (out_free) state_next = pcdp_pkg::ST_IDLE;
      end
      default: state_next = pcdp_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcdp_pkg::NREGS; i++) begin
        nominal_period[i] <= pcdp_pkg::NOMINAL_RESET[i];
      end
    end else if (cfg.valid && (int'(cfg.index) < pcdp_pkg::NREGS)) begin
      nominal_period[cfg.index[pcdp_pkg::CHAN_W-1:0]] <= cfg.data;
    end
  end

  // Channel state and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_edge_time[i]  <= '0;
        last_rise_time[i]  <= '0;
        measured_period[i] <= pcdp_pkg::NOMINAL_RESET[i];
        duty_value[i]      <= '0;
      end
      dupd <= 1'b0;
      pacc <= 1'b0;
    end else begin
      if (state == pcdp_pkg::ST_IDLE && in_fire) begin
        dupd <= 1'b0;
        pacc <= 1'b0;
      end
      if (state == pcdp_pkg::ST_EVAL && ch_ok) begin
        last_edge_time[chi] <= t_r;
        if (lvl_r) begin
          last_rise_time[chi] <= t_r;
          if (in_window) begin
            measured_period[chi] <= ival;
            pacc                 <= 1'b1;
          end
        end
      end
      if (state == pcdp_pkg::ST_DIV && cnt == '0) begin
        duty_value[chi] <= {quot, ge};
        dupd            <= 1'b1;
      end
    end
  end

  // Request latch and divide datapath: payload only, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      t_r   <= edges.edge_time;
      ch_r  <= edges.channel;
      lvl_r <= edges.level;
    end
    if (state == pcdp_pkg::ST_EVAL) begin
      high_r <= high;
      per_r  <= measured_period[chi];
    end
    if (state == pcdp_pkg::ST_MUL) begin
      // high < period, so the upper dividend bits are already below period.
      rem      <= prod[PW-1:DW];
      low_bits <= prod[DW-1:0];
      quot     <= '0;
      cnt      <= CW'(DW - 1);
    end
    if (state == pcdp_pkg::ST_DIV) begin
      rem      <= ge ? diff[TW-1:0] : trial[TW-1:0];
      low_bits <= {low_bits[DW-2:0], 1'b0};
      quot     <= {quot[DW-3:0], ge};
      cnt      <= cnt - 1'b1;
    end
  end

  // Output register: load when the previous result has left.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == pcdp_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pcdp_pkg::ST_DONE && out_free) begin
      if (ch_ok) begin
        out_duty   <= duty_value[chi];
        out_period <= measured_period[chi];
        out_dupd   <= dupd;
        out_pacc   <= pacc;
      end else begin
        // Absent channel: report all zeros, touch nothing.
        out_duty   <= '0;
        out_period <= '0;
        out_dupd   <= 1'b0;
        out_pacc   <= 1'b0;
      end
    end
  end

  assign results.valid           = out_valid;
  assign results.duty            = out_duty;
  assign results.period          = out_period;
  assign results.duty_updated    = out_dupd;
  assign results.period_accepted = out_pacc;

endmodule

[src/pcdp_checker.sv]
// Port-level checks for the PWM capture duty/period core, with its bind.
module pcdp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcdp_pkg::DUTY_W-1:0] duty,
  input logic                        duty_updated,
  input logic                        period_accepted
);

  // One request at a time: ready drops right after acceptance.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("edge request accepted while a previous one is in work");

  // No result can appear in the cycle after reset.
  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // An edge is either rising or falling: never both flags.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(duty_updated && period_accepted))
    else $error("duty and period both updated by one edge");

  // A fresh duty is always below full scale.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_updated |-> (duty < pcdp_pkg::DUTY_FULL))
    else $error("duty out of range");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty))
    else $error("stalled result changed or dropped");

endmodule

bind pwm_capture_duty_period_core pcdp_checker u_pcdp_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (edges.valid),
  .in_ready        (edges.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .duty            (results.duty),
  .duty_updated    (results.duty_updated),
  .period_accepted (results.period_accepted)
);
